// ----- hw/rtl/pbzd_pkg.sv -----
// Shared constants for the potentiometer boxcar / zoom / deadband block.
// Field widths, stream packing widths and configuration register indexes.
// No dependencies.
package pbzd_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int ZOOM_W      = 8;
	localparam int SAMPLE_FULL = (1 << SAMPLE_W) - 1;

	// stream packing, padded to whole bytes
	localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ZOOM_W + SAMPLE_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZOOM_LOW  = 2'd0,
		REG_ZOOM_HIGH = 2'd1,
		REG_DEADBAND  = 2'd2
	} cfg_reg_t;

	localparam logic [ZOOM_W-1:0] ZOOM_LOW_RST  = 8'd50;
	localparam logic [ZOOM_W-1:0] ZOOM_HIGH_RST = 8'd200;
	localparam logic [ZOOM_W-1:0] DEADBAND_RST  = 8'd2;

endpackage

// ----- hw/rtl/pot_boxcar_zoom_deadband.sv -----
// Top level: boxcar average of potentiometer samples, linear zoom mapping and deadband.
// Depends on pbzd_pkg.
//
// Usage:
//  - s_axis carries one 12-bit sample per transfer. m_axis carries one result per
//    reported change: zoom value and the boxcar level that produced it. Samples whose
//    mapped zoom stays within the deadband of the last reported value give no result.
//  - cfg_* writes zoom_low (index 0), zoom_high (1) and change_deadband (2); other
//    indexes are ignored. cfg_ready is always high. Write only while the block is idle.
//  - Throughput: one sample per cycle while m_axis does not stall. A sample passes the
//    registered stages in order: history read, sum update, reciprocal multiply for / TAPS,
//    span multiply, reciprocal multiply for / SAMPLE_MAX, then mapping and deadband compare into the output register.
//  - The history ring lives in a TAPS-entry memory read and written at one address per
//    cycle; the read returns the old entry before the new sample replaces it.
//  - Reset: history reads as zero (per-entry valid bits), sum and ring position clear,
//    last reported value is 0, registers take 50 / 200 / 2. No clearing pass.
//  - When m_axis stalls with a result waiting, the whole pipeline holds and s_axis_tready
//    drops until the result is taken.
module pot_boxcar_zoom_deadband #(
	parameter int TAPS       = 10,
	parameter int SAMPLE_MAX = 4095
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [11:0] sample
	input  logic [pbzd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] zoom_value, [19:8] filtered_level
	output logic [pbzd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pbzd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbzd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pbzd_pkg::*;

	localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SUM_W  = $clog2(TAPS * SAMPLE_FULL + 1);

	// sum / TAPS as multiply by ceil(2^SH/TAPS) and shift; exact for sums below 2^SUM_W
	localparam int     D1_L  = $clog2(TAPS);
	localparam int     D1_SH = SUM_W + D1_L;
	localparam int     D1_MW = SUM_W + 1;
	localparam int     P1_W  = D1_SH + SAMPLE_W;
	localparam longint D1_MV = ((longint'(1) << D1_SH) + TAPS - 1) / TAPS;
	localparam logic [D1_MW-1:0] D1_M = D1_MW'(D1_MV);

	// |level * span| / SAMPLE_MAX the same way
	localparam int     MAG_W = SAMPLE_W + ZOOM_W;
	localparam int     PRD_W = SAMPLE_W + ZOOM_W + 2;
	localparam int     D2_L  = $clog2(SAMPLE_MAX);
	localparam int     D2_SH = MAG_W + D2_L;
	localparam int     D2_MW = MAG_W + 1;
	localparam int     P2_W  = D2_SH + ZOOM_W;
	localparam longint D2_MV = ((longint'(1) << D2_SH) + SAMPLE_MAX - 1) / SAMPLE_MAX;
	localparam logic [D2_MW-1:0] D2_M = D2_MW'(D2_MV);

	// configuration
	logic [ZOOM_W-1:0] zoom_low_q, zoom_high_q, deadband_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_low_q  <= ZOOM_LOW_RST;
			zoom_high_q <= ZOOM_HIGH_RST;
			deadband_q  <= DEADBAND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ZOOM_LOW:  zoom_low_q  <= cfg_data;
				REG_ZOOM_HIGH: zoom_high_q <= cfg_data;
				REG_DEADBAND:  deadband_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: everything advances together unless a result is stuck
	logic adv, acc;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	logic [SAMPLE_W-1:0] sample_in;
	assign sample_in = s_axis_tdata[SAMPLE_W-1:0];

	// history memory, read-first
	logic [SAMPLE_W-1:0] hist_mem [TAPS];
	logic [TAPS-1:0]     hist_valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SAMPLE_W-1:0] rd_s1, sample_s1;
	logic                rd_valid_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1            <= hist_mem[slot_q];
			hist_mem[slot_q] <= sample_in;
			sample_s1        <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			slot_q       <= '0;
			rd_valid_s1  <= 1'b0;
		end else if (acc) begin
			rd_valid_s1          <= hist_valid_q[slot_q];
			hist_valid_q[slot_q] <= 1'b1;
			slot_q <= (slot_q == SLOT_W'(TAPS - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// s1: running sum
	logic [SUM_W-1:0] sum_q, sum_next, sum_s2;
	logic [SAMPLE_W-1:0] old_s1;

	assign old_s1   = rd_valid_s1 ? rd_s1 : '0;
	assign sum_next = sum_q - SUM_W'(old_s1) + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && v_s1) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_next;
		end
	end

	// s2: divide by TAPS
	logic [P1_W-1:0] quot1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			quot1_s3 <= P1_W'(sum_s2) * P1_W'(D1_M);
		end
	end

	// s3: saturate level, multiply by span
	logic [SAMPLE_W-1:0]      avg_s3, lvl_s3, lvl_s4, lvl_s5;
	logic signed [ZOOM_W:0]   span;
	logic signed [PRD_W-1:0]  prod_s4;

	assign avg_s3 = quot1_s3[D1_SH +: SAMPLE_W];
	assign lvl_s3 = (int'(avg_s3) > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : avg_s3;
	assign span   = $signed({1'b0, zoom_high_q}) - $signed({1'b0, zoom_low_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= PRD_W'($signed({1'b0, lvl_s3}) * span);
			lvl_s4  <= lvl_s3;
		end
	end

	// s4: |prod| / SAMPLE_MAX, truncating toward zero
	logic [PRD_W-1:0] prod_abs;
	logic [P2_W-1:0]  quot2_s5;
	logic             neg_s5;

	assign prod_abs = prod_s4[PRD_W-1] ? PRD_W'(-prod_s4) : PRD_W'(prod_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			quot2_s5 <= P2_W'(prod_abs[MAG_W-1:0]) * P2_W'(D2_M);
			neg_s5   <= prod_s4[PRD_W-1];
			lvl_s5   <= lvl_s4;
		end
	end

	// s5: offset, deadband against the last reported value
	logic [ZOOM_W-1:0] quot2, zoom_s5, last_q;
	logic [ZOOM_W:0]   zoom_w, diff, diff_abs;
	logic              emit_s5;

	assign quot2    = quot2_s5[D2_SH +: ZOOM_W];
	assign zoom_w   = neg_s5 ? {1'b0, zoom_low_q} - {1'b0, quot2}
	                         : {1'b0, zoom_low_q} + {1'b0, quot2};
	assign zoom_s5  = zoom_w[ZOOM_W-1:0];
	assign diff     = {1'b0, zoom_s5} - {1'b0, last_q};
	assign diff_abs = diff[ZOOM_W] ? -diff : diff;
	assign emit_s5  = v_s5 && (diff_abs > {1'b0, deadband_q});

	logic [ZOOM_W-1:0]   zoom_out_q;
	logic [SAMPLE_W-1:0] level_out_q;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit_s5;
			if (emit_s5) begin
				last_q <= zoom_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s5) begin
			zoom_out_q  <= zoom_s5;
			level_out_q <= lvl_s5;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({level_out_q, zoom_out_q});

	// checks
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> slot_q == (($past(slot_q) == SLOT_W'(TAPS - 1)) ? '0 : $past(slot_q) + 1'b1))
		else $error("ring position did not advance by one");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv |=> int'(sum_q) <= TAPS * SAMPLE_FULL)
		else $error("running sum out of range");

	a_last_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q != $past(last_q)) |-> (m_axis_tvalid && zoom_out_q == last_q))
		else $error("last reported value changed without a result");

	a_zoom_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((zoom_out_q >= zoom_low_q && zoom_out_q <= zoom_high_q) ||
			 (zoom_out_q <= zoom_low_q && zoom_out_q >= zoom_high_q)))
		else $error("zoom value outside the configured range");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for pot_boxcar_zoom_deadband: directed corner tests, then phased random
// sample traffic, checked against an in-bench boxcar / zoom / deadband predictor.
// Depends on pbzd_pkg and the pot_boxcar_zoom_deadband RTL.
module tb;
	import pbzd_pkg::*;

	localparam int FILTER_TAPS = 10;
	localparam int LEVEL_MAX   = SAMPLE_FULL;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_LIST = 2'd3;

	typedef struct packed {
		logic [ZOOM_W-1:0]   zoom;
		logic [SAMPLE_W-1:0] level;
	} zoom_report_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor state
	logic [SAMPLE_W-1:0] ring_hist [FILTER_TAPS];
	int                  ring_pos;
	int                  ring_sum;
	logic [ZOOM_W-1:0]   last_zoom;
	logic [ZOOM_W-1:0]   reg_zoom_low;
	logic [ZOOM_W-1:0]   reg_zoom_high;
	logic [ZOOM_W-1:0]   reg_deadband;

	zoom_report_t expected_reports [$];

	int  mismatches;
	int  samples_sent;
	int  reports_predicted;
	int  reports_checked;
	int  cfg_writes;
	bit  steady_flow;

	pot_boxcar_zoom_deadband #(
		.TAPS       (FILTER_TAPS),
		.SAMPLE_MAX (LEVEL_MAX)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void reset_filter_model();
		foreach (ring_hist[i])
			ring_hist[i] = '0;
		ring_pos      = 0;
		ring_sum      = 0;
		last_zoom     = '0;
		reg_zoom_low  = ZOOM_LOW_RST;
		reg_zoom_high = ZOOM_HIGH_RST;
		reg_deadband  = DEADBAND_RST;
	endfunction

	// one accepted sample: update the boxcar, map to zoom, apply deadband
	function automatic void advance_filter(input logic [SAMPLE_W-1:0] s);
		int level;
		int span;
		int zoom;
		int diff;
		zoom_report_t rep;
		ring_sum = ring_sum - ring_hist[ring_pos] + s;
		ring_hist[ring_pos] = s;
		ring_pos = (ring_pos == FILTER_TAPS - 1) ? 0 : ring_pos + 1;
		level = ring_sum / FILTER_TAPS;
		if (level > LEVEL_MAX)
			level = LEVEL_MAX;
		span = int'(reg_zoom_high) - int'(reg_zoom_low);
		// signed int division truncates toward zero, also for a descending range
		zoom = level * span / LEVEL_MAX + int'(reg_zoom_low);
		diff = zoom - int'(last_zoom);
		if (diff < 0)
			diff = -diff;
		samples_sent++;
		if (diff > int'(reg_deadband)) begin
			last_zoom = zoom[ZOOM_W-1:0];
			rep.zoom  = zoom[ZOOM_W-1:0];
			rep.level = level[SAMPLE_W-1:0];
			expected_reports.push_back(rep);
			reports_predicted++;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_FULL)
			return SAMPLE_FULL[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

	// call at a rising edge; returns at the edge of the transfer
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(s);
		do @(posedge clk); while (!s_axis_tready);
		advance_filter(s);
	endtask

	// wait for every pending report, then for samples that produce none
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
			REG_ZOOM_LOW:  reg_zoom_low  = val;
			REG_ZOOM_HIGH: reg_zoom_high = val;
			REG_DEADBAND:  reg_deadband  = val;
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mapping(input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] db);
		settle();
		write_reg(REG_ZOOM_LOW, lo);
		write_reg(REG_ZOOM_HIGH, hi);
		write_reg(REG_DEADBAND, db);
	endtask

	// reset register values, ring warm-up from zero
	task automatic test_reset_defaults();
		repeat (5) send_sample(12'hFFF);
	endtask

	task automatic test_range_extremes();
		set_mapping(8'd0, 8'd255, 8'd0);
		repeat (5) send_sample(12'hFFF);
		send_sample(12'hAAA);
		send_sample(12'h555);
	endtask

	task automatic test_reversed_range();
		set_mapping(8'd255, 8'd0, 8'd1);
		repeat (4) send_sample(12'h000);
		send_sample(12'h800);
		send_sample(12'hFFF);
	endtask

	task automatic test_flat_range();
		set_mapping(8'd128, 8'd128, 8'd0);
		send_sample(12'h000);
		send_sample(12'hFFF);
	endtask

	// a write to an unlisted index must not disturb any register
	task automatic test_unlisted_index();
		settle();
		write_reg(REG_OUT_OF_LIST, 8'hFF);
		send_sample(12'hFFF);
		send_sample(12'h000);
	endtask

	task automatic test_wide_deadband();
		set_mapping(8'd0, 8'd255, 8'd255);
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(12'h000);
	endtask

	// phases of steps, ramps, noise and spikes under varied mappings
	task automatic test_random_traffic();
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] db;
		int phase_items;
		int phase_base;
		int seg_len;
		int kind;
		int base;
		int target;
		bit want_reports;
		for (int phase = 0; phase < 8; phase++) begin
			lo = 8'($urandom_range(0, 255));
			hi = 8'($urandom_range(0, 255));
			db = 8'($urandom_range(0, 12));
			unique case (phase)
				0: begin lo = 8'd0;   hi = 8'd255; db = 8'd0; end
				1: begin lo = 8'd255; hi = 8'd0;   end
				2: hi = lo;
				6: db = 8'($urandom_range(13, 80));
				7: db = 8'($urandom_range(200, 255));
				default: ;
			endcase
			set_mapping(lo, hi, db);
			// a flat range reports at most once, so it gets no extra items
			want_reports = (db < 64) && (lo != hi);
			phase_items = 0;
			phase_base = reports_predicted;
			while (phase_items < 200 || (want_reports && phase_items < 300 &&
					reports_predicted - phase_base < 30)) begin
				kind = $urandom_range(0, 9);
				steady_flow = ($urandom_range(0, 4) == 0);
				if (kind <= 4) begin
					// hold a level with a little jitter so the average settles
					seg_len = $urandom_range(10, 30);
					base = $urandom_range(0, SAMPLE_FULL);
					for (int k = 0; k < seg_len; k++)
						send_sample(clip_sample(base + $urandom_range(0, 16) - 8));
				end else if (kind <= 7) begin
					seg_len = $urandom_range(10, 40);
					base = $urandom_range(0, SAMPLE_FULL);
					target = $urandom_range(0, SAMPLE_FULL);
					for (int k = 0; k < seg_len; k++)
						send_sample(clip_sample(base + (target - base) * k / seg_len));
				end else if (kind == 8) begin
					seg_len = $urandom_range(1, 10);
					for (int k = 0; k < seg_len; k++)
						send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_FULL)));
				end else begin
					seg_len = $urandom_range(1, 6);
					for (int k = 0; k < seg_len; k++)
						send_sample($urandom_range(0, 1) ? 12'hFFF : 12'h000);
				end
				phase_items += seg_len;
			end
		end
		steady_flow = 1'b0;
	endtask

	// result sink: random stall before each transfer, none during steady flow
	initial begin : sink_pacing
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		zoom_report_t exp_rep;
		logic [ZOOM_W-1:0]   got_zoom;
		logic [SAMPLE_W-1:0] got_level;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_zoom  = m_axis_tdata[ZOOM_W-1:0];
			got_level = m_axis_tdata[ZOOM_W+SAMPLE_W-1:ZOOM_W];
			reports_checked++;
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected report zoom=%0d level=%0d",
					got_zoom, got_level));
			end else begin
				exp_rep = expected_reports.pop_front();
				if (got_zoom !== exp_rep.zoom)
					report_mismatch($sformatf("zoom_value %0d, expected %0d",
						got_zoom, exp_rep.zoom));
				if (got_level !== exp_rep.level)
					report_mismatch($sformatf("filtered_level %0d, expected %0d",
						got_level, exp_rep.level));
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ZOOM_LOW;
		cfg_data      = '0;
		steady_flow   = 1'b0;
		mismatches    = 0;
		samples_sent  = 0;
		reports_predicted = 0;
		reports_checked   = 0;
		cfg_writes    = 0;
		reset_filter_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_range_extremes();
		test_reversed_range();
		test_flat_range();
		test_unlisted_index();
		test_wide_deadband();
		test_random_traffic();
		settle();

		$display("covered %0d samples and %0d register writes; %0d zoom reports checked",
			samples_sent, cfg_writes, reports_checked);
		$display("mappings: full, reversed, flat and random ranges; deadband 0 up to 255");
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("pot_boxcar_zoom_deadband regression: pass");
		end else begin
			$display("pot_boxcar_zoom_deadband regression: fail");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout: %0d reports still pending", expected_reports.size());
		$display("pot_boxcar_zoom_deadband regression: fail");
		$finish;
	end

endmodule

// ----- pot_boxcar_zoom_deadband.f -----
hw/rtl/pbzd_pkg.sv
hw/rtl/pot_boxcar_zoom_deadband.sv
tb/tb.sv
